// ===== rtl/core/iq_lag_correlation_stats_macros.svh =====
// ----------------------------------------------------------------------------
// IQ lag correlation stats - assertion macros
// Shared concurrent assertion forms, clocked on i_clk with i_rst_n low masking.
// ----------------------------------------------------------------------------
`ifndef IQ_LAG_CORRELATION_STATS_MACROS_SVH
`define IQ_LAG_CORRELATION_STATS_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IQLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define IQLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/iqlc_pkg.sv =====
// ----------------------------------------------------------------------------
// IQ lag correlation stats - package
// Widths, limits, shared types and saturating adders.
// ----------------------------------------------------------------------------
package iqlc_pkg;

    localparam int RAW_W            = 16;
    localparam int SAMP_W           = 12;
    localparam int SUM_W            = 22;
    localparam int PROD_W           = 34;
    localparam int MUL_W            = 2 * SAMP_W;
    localparam int MAX_SLOT_SAMPLES = 1024;
    localparam int NUM_LAGS         = 4;
    localparam int HIST_D           = NUM_LAGS - 1;
    localparam int CNT_W            = $clog2(MAX_SLOT_SAMPLES + 1);
    localparam int LAG_W            = 2;

    localparam int IN_DATA_W     = 2 * RAW_W;
    localparam int OUT_FIELD_W   = LAG_W + 2 * SUM_W + 4 * PROD_W + 1;
    localparam int OUT_DATA_W    = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_DATA_W - OUT_FIELD_W;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_SLOT_SAMPLES);
    localparam logic [LAG_W-1:0] LAST_LAG = LAG_W'(NUM_LAGS - 1);

    typedef logic signed [SAMP_W-1:0] t_samp;

    typedef struct packed {
        logic  valid;
        t_samp si;
        t_samp sq;
        logic  slot_end;
    } t_sample;

    typedef struct packed {
        logic signed [PROD_W-1:0] ii;
        logic signed [PROD_W-1:0] qq;
        logic signed [PROD_W-1:0] iq;
        logic signed [PROD_W-1:0] qi;
    } t_lag_acc;

    typedef struct packed {
        logic                    load;
        logic                    overrun;
        logic signed [SUM_W-1:0] sum_i;
        logic signed [SUM_W-1:0] sum_q;
        t_lag_acc [NUM_LAGS-1:0] lags;
    } t_snapshot;

    function automatic logic signed [SUM_W-1:0] sat_sum(
        input logic signed [SUM_W-1:0]  acc,
        input logic signed [SAMP_W-1:0] add
    );
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(acc) + (SUM_W+1)'(add);
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

    function automatic logic signed [PROD_W-1:0] sat_prod(
        input logic signed [PROD_W-1:0] acc,
        input logic signed [MUL_W-1:0]  add
    );
        logic signed [PROD_W:0] s;
        s = (PROD_W+1)'(acc) + (PROD_W+1)'(add);
        if (s[PROD_W] != s[PROD_W-1]) begin
            return s[PROD_W] ? {1'b1, {(PROD_W-1){1'b0}}} : {1'b0, {(PROD_W-1){1'b1}}};
        end
        return s[PROD_W-1:0];
    endfunction

endpackage

// ===== rtl/core/iqlc_in_reg.sv =====
// ----------------------------------------------------------------------------
// IQ lag correlation stats - input register
// Decodes the raw words to 12-bit samples and holds one item for the accumulator.
// ----------------------------------------------------------------------------
module iqlc_in_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tvalid,
    output logic                          o_tready,
    input  logic [iqlc_pkg::IN_DATA_W-1:0] i_tdata,
    input  logic                          i_tlast,
    input  logic                          i_take,
    output iqlc_pkg::t_sample             o_sample
);

    logic                  r_valid;
    iqlc_pkg::t_samp       r_si;
    iqlc_pkg::t_samp       r_sq;
    logic                  r_end;
    logic                  w_load;

    assign o_tready = !r_valid || i_take;
    assign w_load   = i_tvalid && o_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // sample sits in bits 15..4 of each raw word
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_si  <= i_tdata[iqlc_pkg::RAW_W-1 -: iqlc_pkg::SAMP_W];
            r_sq  <= i_tdata[2*iqlc_pkg::RAW_W-1 -: iqlc_pkg::SAMP_W];
            r_end <= i_tlast;
        end
    end

    always_comb begin
        o_sample.valid    = r_valid;
        o_sample.si       = r_si;
        o_sample.sq       = r_sq;
        o_sample.slot_end = r_end;
    end

endmodule

// ===== rtl/core/iqlc_accum.sv =====
// ----------------------------------------------------------------------------
// IQ lag correlation stats - accumulator
// Delay line, sample count and all saturating lag sums; up to one item a cycle.
// ----------------------------------------------------------------------------
module iqlc_accum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iqlc_pkg::t_sample   i_sample,
    input  logic                i_buf_free,
    output logic                o_take,
    output iqlc_pkg::t_snapshot o_snap
);

    iqlc_pkg::t_samp                        r_hist_i [iqlc_pkg::HIST_D];
    iqlc_pkg::t_samp                        r_hist_q [iqlc_pkg::HIST_D];
    logic [iqlc_pkg::CNT_W-1:0]             r_count;
    logic signed [iqlc_pkg::SUM_W-1:0]      r_sum_i;
    logic signed [iqlc_pkg::SUM_W-1:0]      r_sum_q;
    iqlc_pkg::t_lag_acc [iqlc_pkg::NUM_LAGS-1:0] r_acc;
    logic                                   r_ovf;

    logic [iqlc_pkg::CNT_W-1:0]             n_count;
    logic signed [iqlc_pkg::SUM_W-1:0]      n_sum_i;
    logic signed [iqlc_pkg::SUM_W-1:0]      n_sum_q;
    iqlc_pkg::t_lag_acc [iqlc_pkg::NUM_LAGS-1:0] n_acc;
    logic                                   n_ovf;

    iqlc_pkg::t_samp                        w_op_i [iqlc_pkg::NUM_LAGS];
    iqlc_pkg::t_samp                        w_op_q [iqlc_pkg::NUM_LAGS];
    logic signed [iqlc_pkg::MUL_W-1:0]      w_p_ii [iqlc_pkg::NUM_LAGS];
    logic signed [iqlc_pkg::MUL_W-1:0]      w_p_qq [iqlc_pkg::NUM_LAGS];
    logic signed [iqlc_pkg::MUL_W-1:0]      w_p_iq [iqlc_pkg::NUM_LAGS];
    logic signed [iqlc_pkg::MUL_W-1:0]      w_p_qi [iqlc_pkg::NUM_LAGS];
    logic                                   w_close;

    assign o_take  = i_sample.valid && (!i_sample.slot_end || i_buf_free);
    assign w_close = o_take && i_sample.slot_end;

    always_comb begin
        n_ovf   = r_ovf || (r_count >= iqlc_pkg::CNT_MAX);
        n_sum_i = iqlc_pkg::sat_sum(r_sum_i, i_sample.si);
        n_sum_q = iqlc_pkg::sat_sum(r_sum_q, i_sample.sq);
        n_count = (r_count < iqlc_pkg::CNT_MAX) ? r_count + 1'b1 : r_count;

        w_op_i[0] = i_sample.si;
        w_op_q[0] = i_sample.sq;
        for (int m = 1; m < iqlc_pkg::NUM_LAGS; m++) begin
            w_op_i[m] = r_hist_i[m-1];
            w_op_q[m] = r_hist_q[m-1];
        end

        // lag m counts only once m earlier samples of this slot exist
        for (int m = 0; m < iqlc_pkg::NUM_LAGS; m++) begin
            w_p_ii[m] = w_op_i[m] * i_sample.si;
            w_p_qq[m] = w_op_q[m] * i_sample.sq;
            w_p_iq[m] = w_op_i[m] * i_sample.sq;
            w_p_qi[m] = w_op_q[m] * i_sample.si;
            n_acc[m]  = r_acc[m];
            if (iqlc_pkg::CNT_W'(m) <= r_count) begin
                n_acc[m].ii = iqlc_pkg::sat_prod(r_acc[m].ii, w_p_ii[m]);
                n_acc[m].qq = iqlc_pkg::sat_prod(r_acc[m].qq, w_p_qq[m]);
                n_acc[m].iq = iqlc_pkg::sat_prod(r_acc[m].iq, w_p_iq[m]);
                n_acc[m].qi = iqlc_pkg::sat_prod(r_acc[m].qi, w_p_qi[m]);
            end
        end
    end

    always_comb begin
        o_snap.load    = w_close;
        o_snap.overrun = n_ovf;
        o_snap.sum_i   = n_sum_i;
        o_snap.sum_q   = n_sum_q;
        o_snap.lags    = n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_close) begin
            for (int k = 0; k < iqlc_pkg::HIST_D; k++) begin
                r_hist_i[k] <= '0;
                r_hist_q[k] <= '0;
            end
            r_count <= '0;
            r_sum_i <= '0;
            r_sum_q <= '0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
        end else if (o_take) begin
            r_hist_i[0] <= i_sample.si;
            r_hist_q[0] <= i_sample.sq;
            for (int k = 1; k < iqlc_pkg::HIST_D; k++) begin
                r_hist_i[k] <= r_hist_i[k-1];
                r_hist_q[k] <= r_hist_q[k-1];
            end
            r_count <= n_count;
            r_sum_i <= n_sum_i;
            r_sum_q <= n_sum_q;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ===== rtl/core/iqlc_out_buf.sv =====
// ----------------------------------------------------------------------------
// IQ lag correlation stats - result buffer
// Holds one slot's results and shifts them out one lag per accepted item.
// ----------------------------------------------------------------------------
module iqlc_out_buf (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  iqlc_pkg::t_snapshot             i_snap,
    output logic                            o_buf_free,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [iqlc_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic                            o_tlast
);

    logic                                   r_busy;
    logic [iqlc_pkg::LAG_W-1:0]             r_idx;
    iqlc_pkg::t_lag_acc [iqlc_pkg::NUM_LAGS-1:0] r_lags;
    logic signed [iqlc_pkg::SUM_W-1:0]      r_sum_i;
    logic signed [iqlc_pkg::SUM_W-1:0]      r_sum_q;
    logic                                   r_ovf;
    logic                                   w_take;
    logic                                   w_last;

    assign w_take     = r_busy && i_tready;
    assign w_last     = (r_idx == iqlc_pkg::LAST_LAG);
    // a new snapshot may land as the last lag leaves
    assign o_buf_free = !r_busy || (i_tready && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_snap.load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_take) begin
            r_busy <= !w_last;
            r_idx  <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap.load) begin
            r_lags  <= i_snap.lags;
            r_sum_i <= i_snap.sum_i;
            r_sum_q <= i_snap.sum_q;
            r_ovf   <= i_snap.overrun;
        end else if (w_take) begin
            for (int k = 0; k < iqlc_pkg::NUM_LAGS - 1; k++) begin
                r_lags[k] <= r_lags[k+1];
            end
        end
    end

    assign o_tvalid = r_busy;
    assign o_tlast  = w_last;
    assign o_tdata  = {{iqlc_pkg::OUT_PAD_W{1'b0}}, r_ovf,
                       r_lags[0].qi, r_lags[0].iq, r_lags[0].qq, r_lags[0].ii,
                       r_sum_q, r_sum_i, r_idx};

endmodule

// ===== rtl/core/iq_lag_correlation_stats.sv =====
// ----------------------------------------------------------------------------
// IQ lag correlation stats - top level
// I/Q lag autocorrelation sums per slot, four lags, up to one sample per cycle.
// ----------------------------------------------------------------------------
// Input stream: one complex sample per item, raw I and Q words; tlast marks
// the final sample of a slot. Samples are taken one per cycle unless stalled.
// Each sample passes an input register, then a combinational multiply and
// saturating accumulate for all four lags (sixteen 12x12 products in parallel).
// The slot's final sample loads a four-entry result buffer and clears the
// accumulators, so the next slot starts at once on the following item.
// Output stream: four items per slot, lag 0 to lag 3, tlast on lag 3.
// The first result is valid once the final sample loads the result buffer;
// the rest follow one per cycle while the receiver is ready.
// Throughput: one sample per cycle; a slot needs at least four samples to
// sustain that rate, since the result buffer drains one lag per cycle.
// If the receiver stalls, the buffer holds; a further slot end then waits in
// the input register and s_axis_tready drops until the buffer frees.
// Reset (synchronous, active low) clears the delay line, counts, sums and
// any results not yet delivered.
// ----------------------------------------------------------------------------
`include "iq_lag_correlation_stats_macros.svh"

module iq_lag_correlation_stats (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // raw_i [15:0], raw_q [31:16]
    input  logic [iqlc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // slot_end
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // lag [1:0], sum_i [23:2], sum_q [45:24], prod_ii [79:46], prod_qq [113:80],
    // prod_iq [147:114], prod_qi [181:148], overrun [182], zero pad [183]
    output logic [iqlc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // last_result
    output logic                            m_axis_tlast
);

    iqlc_pkg::t_sample   w_sample;
    iqlc_pkg::t_snapshot w_snap;
    logic                w_take;
    logic                w_buf_free;

    iqlc_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tlast  (s_axis_tlast),
        .i_take   (w_take),
        .o_sample (w_sample)
    );

    iqlc_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (w_sample),
        .i_buf_free (w_buf_free),
        .o_take     (w_take),
        .o_snap     (w_snap)
    );

    iqlc_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_snap     (w_snap),
        .o_buf_free (w_buf_free),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tlast    (m_axis_tlast)
    );

    `IQLC_ASSERT_NEXT(a_slot_close_loads, w_take && w_sample.slot_end, m_axis_tvalid && (m_axis_tdata[iqlc_pkg::LAG_W-1:0] == '0), "slot end did not present lag 0")
    `IQLC_ASSERT_NEXT(a_lag_advance, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[iqlc_pkg::LAG_W-1:0] == $past(m_axis_tdata[iqlc_pkg::LAG_W-1:0]) + 1'b1), "result lags not consecutive")
    `IQLC_ASSERT_NOW(a_stall_cause, !s_axis_tready, w_sample.valid && w_sample.slot_end && !w_buf_free, "input stalled without a blocked slot end")

endmodule
